// ----- sv/grouped_relay_button_panel_core_assert.svh -----
// Assertion macros for the grouped relay button panel core.
`ifndef GROUPED_RELAY_BUTTON_PANEL_CORE_ASSERT_SVH
`define GROUPED_RELAY_BUTTON_PANEL_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GRBP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define GRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/grbp_pkg.sv -----
// Shared types and constants of the grouped relay button panel.
package grbp_pkg;

	typedef logic [1:0] mode_t;
	typedef logic [1:0] event_t;

	localparam mode_t MODE_STARTUP = 2'd0;
	localparam mode_t MODE_NORMAL  = 2'd1;
	localparam mode_t MODE_PROG    = 2'd2;

	localparam event_t EV_NONE  = 2'd0;
	localparam event_t EV_SHORT = 2'd1;
	localparam event_t EV_LONG  = 2'd2;

	localparam logic CFG_LONG_PRESS = 1'b0;
	localparam logic CFG_FILL_MASK  = 1'b1;

	localparam logic [7:0] PB_KEEP    = 8'hCF;
	localparam logic [7:0] PB_RAW_HI  = 8'h20;
	localparam logic [7:0] PB_RAW_LO  = 8'h10;
	localparam int         MASTER_IDX = 6;

	localparam logic [7:0] TIMER_MAX        = 8'hFF;
	localparam logic [7:0] LONG_PRESS_RESET = 8'd31;
	localparam logic [7:0] FILL_MASK_RESET  = 8'd192;

	localparam logic [3:0] FLASH_ON_LIMIT = 4'd5;
	localparam logic [3:0] FLASH_WRAP     = 4'd9;
	localparam logic [3:0] FLASH_STEP     = 4'h1;

	localparam int GRP_W         = 3;
	localparam int GROUP_CODES_W = 18;

	// control from the mode logic to the group table
	typedef struct packed {
		logic rebuild; // rebuild masks from the current group table
		logic bump;    // step the group of every edge button
	} grp_ctrl_t;

endpackage

// ----- sv/grbp_master.sv -----
// Master button short/long press timer.
module grbp_master (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                master_edge,
	input  logic                master_level,
	input  logic [7:0]          long_press_ticks,
	output grbp_pkg::event_t    ev
);
	import grbp_pkg::*;

	logic [7:0] timer_q;
	logic       running_q;
	logic       active_q;
	logic [7:0] timer_d;
	logic [7:0] timer_inc;
	logic       running_d;
	logic       active_d;

	always_comb begin
		timer_inc = (running_q && timer_q != TIMER_MAX) ? timer_q + 8'd1 : timer_q;
		timer_d   = timer_inc;
		running_d = running_q;
		active_d  = active_q;
		ev        = EV_NONE;
		if (master_edge) begin
			// timer restarts without clearing
			running_d = 1'b1;
			active_d  = 1'b1;
			ev        = EV_SHORT;
		end else if (running_q && timer_inc >= long_press_ticks) begin
			running_d = 1'b0;
			active_d  = 1'b0;
			timer_d   = '0;
			ev        = EV_LONG;
		end else if (active_q && !master_level) begin
			running_d = 1'b0;
			active_d  = 1'b0;
			timer_d   = '0;
			ev        = EV_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q   <= '0;
			running_q <= 1'b0;
			active_q  <= 1'b0;
		end else if (step) begin
			timer_q   <= timer_d;
			running_q <= running_d;
			active_q  <= active_d;
		end
	end

endmodule

// ----- sv/grbp_groups.sv -----
// Button-to-group table, group masks and relay toggle selection.
module grbp_groups #(
	parameter int NUM_BUTTONS = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  grbp_pkg::grp_ctrl_t                ctrl,
	input  logic [NUM_BUTTONS-1:0]             edges,
	input  logic [NUM_BUTTONS-1:0]             relay_base,
	output logic [NUM_BUTTONS-1:0]             toggle,
	output logic [grbp_pkg::GROUP_CODES_W-1:0] codes
);
	import grbp_pkg::*;

	logic [GRP_W-1:0]       group_q [NUM_BUTTONS];
	logic [GRP_W-1:0]       group_d [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] mask_q  [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] mask_new[NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] sel     [NUM_BUTTONS];

	// mask of each button's group, decoded AND-OR select
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			sel[i] = '0;
			for (int m = 0; m < NUM_BUTTONS; m++)
				if (group_q[i] == GRP_W'(m))
					sel[i] = sel[i] | mask_q[m];
		end
	end

	always_comb begin
		toggle = '0;
		for (int i = 0; i < NUM_BUTTONS; i++)
			if (edges[i])
				toggle = toggle | (sel[i] ^ relay_base);
	end

	always_comb begin
		for (int m = 0; m < NUM_BUTTONS; m++)
			for (int b = 0; b < NUM_BUTTONS; b++)
				mask_new[m][b] = (group_q[b] == GRP_W'(m));
	end

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			group_d[i] = group_q[i];
			if (ctrl.bump && edges[i])
				group_d[i] = (group_q[i] == GRP_W'(NUM_BUTTONS - 1)) ?
					'0 : group_q[i] + GRP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				group_q[i] <= GRP_W'(i);
				mask_q[i]  <= NUM_BUTTONS'(1) << i;
			end
		end else begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				group_q[i] <= group_d[i];
				if (ctrl.rebuild)
					mask_q[i] <= mask_new[i];
			end
		end
	end

	// codes after this transaction; groups past bit 17 drop off
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_codes
		if (GRP_W * i + GRP_W <= GROUP_CODES_W) begin : g_fit
			assign codes[GRP_W*i +: GRP_W] = group_d[i];
		end
	end
	if (GRP_W * NUM_BUTTONS < GROUP_CODES_W) begin : g_pad
		assign codes[GROUP_CODES_W-1:GRP_W*NUM_BUTTONS] = '0;
	end

endmodule

// ----- sv/grouped_relay_button_panel_core.sv -----
// Top level of the grouped relay button panel core.
//
// One transaction per periodic tick: the raw button byte goes into an input
// register, the mode, relay, group and press-timer logic runs combinationally
// behind it, and the result lands in an output register. A new tick is taken
// every clock cycle while the result side keeps up. result_valid rises once the
// tick has moved from the input register into the result register, which a
// stalled result can hold back. The input stalls only while the input register
// holds a tick and the result register holds a result that is stalled.
// Configuration registers (long press length, relay fill mask) take effect on
// the next tick and should only be written while no tick is in flight.
module grouped_relay_button_panel_core #(
	parameter int NUM_BUTTONS = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [7:0]                         cfg_data,
	input  logic                               button_valid,
	output logic                               button_stall,
	input  logic [7:0]                         button_byte,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [7:0]                         relay_port,
	output logic                               relay_written,
	output grbp_pkg::mode_t                    panel_mode,
	output grbp_pkg::event_t                   master_event,
	output logic                               fade_start,
	output logic                               fade_stop,
	output logic                               master_light,
	output logic [grbp_pkg::GROUP_CODES_W-1:0] group_codes
);
	import grbp_pkg::*;

	logic [7:0] long_press_q;
	logic [7:0] fill_mask_q;

	logic       valid_s1;
	logic [7:0] button_byte_s1;
	logic       advance;

	logic [7:0]             last_q;
	mode_t                  mode_q;
	logic [NUM_BUTTONS-1:0] relay_q;
	logic [3:0]             flash_q;

	logic [7:0]             pb;
	logic [7:0]             edges;
	event_t                 ev;
	grp_ctrl_t              grp_ctrl;
	logic [NUM_BUTTONS-1:0] relay_base;
	logic [NUM_BUTTONS-1:0] toggle;
	logic [GROUP_CODES_W-1:0] codes;

	mode_t                  mode_d;
	logic [NUM_BUTTONS-1:0] relay_d;
	logic [3:0]             flash_d;
	logic                   written;
	logic                   light;
	logic                   fs;
	logic                   fe;

	logic                     result_valid_q;
	logic [7:0]               relay_port_s2;
	logic                     relay_written_s2;
	mode_t                    panel_mode_s2;
	event_t                   master_event_s2;
	logic                     fade_start_s2;
	logic                     fade_stop_s2;
	logic                     master_light_s2;
	logic [GROUP_CODES_W-1:0] group_codes_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= LONG_PRESS_RESET;
			fill_mask_q  <= FILL_MASK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				CFG_FILL_MASK:  fill_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick moves into the result register when that slot is free or draining
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign button_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (button_valid && !button_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (button_valid && !button_stall)
			button_byte_s1 <= button_byte;
	end

	// raw bits 4 and 5 trade places, bit 6 is the master
	assign pb    = (button_byte_s1 & PB_KEEP) | ((button_byte_s1 & PB_RAW_HI) >> 1) |
		((button_byte_s1 & PB_RAW_LO) << 1);
	assign edges = pb & ~last_q;

	grbp_master u_master (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.master_edge      (edges[MASTER_IDX]),
		.master_level     (pb[MASTER_IDX]),
		.long_press_ticks (long_press_q),
		.ev               (ev)
	);

	// any master event clears relays before the edge toggles are applied
	assign relay_base       = (ev != EV_NONE) ? '0 : relay_q;
	assign grp_ctrl.rebuild = advance && mode_q == MODE_PROG && ev != EV_NONE;
	assign grp_ctrl.bump    = advance && mode_q == MODE_PROG;

	grbp_groups #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_groups (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (grp_ctrl),
		.edges      (edges[NUM_BUTTONS-1:0]),
		.relay_base (relay_base),
		.toggle     (toggle),
		.codes      (codes)
	);

	always_comb begin
		mode_d  = mode_q;
		relay_d = relay_q;
		flash_d = flash_q;
		written = 1'b0;
		light   = 1'b1;
		fs      = 1'b0;
		fe      = 1'b0;
		case (mode_q)
			MODE_NORMAL: begin
				if (ev != EV_NONE) begin
					relay_d = '0;
					written = 1'b1;
				end
				if (ev == EV_LONG)
					mode_d = MODE_PROG;
				if (edges != '0) begin
					relay_d = toggle;
					written = 1'b1;
				end
				// relay state only changes here, so relay_q is the previous value
				fs = (relay_d != '0) && (relay_q == '0);
				fe = (relay_d == '0) && (relay_q != '0);
			end
			MODE_PROG: begin
				light   = flash_q < FLASH_ON_LIMIT;
				flash_d = ((flash_q > FLASH_WRAP) ? 4'd0 : flash_q) + FLASH_STEP;
				if (ev != EV_NONE) begin
					mode_d = MODE_NORMAL;
					light  = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			mode_q  <= MODE_STARTUP;
			relay_q <= '0;
			flash_q <= '0;
		end else if (advance) begin
			last_q  <= pb;
			mode_q  <= mode_d;
			relay_q <= relay_d;
			flash_q <= flash_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			relay_port_s2    <= 8'(relay_d) | fill_mask_q;
			relay_written_s2 <= written;
			panel_mode_s2    <= mode_d;
			master_event_s2  <= ev;
			fade_start_s2    <= fs;
			fade_stop_s2     <= fe;
			master_light_s2  <= light;
			group_codes_s2   <= codes;
		end
	end

	assign result_valid  = result_valid_q;
	assign relay_port    = relay_port_s2;
	assign relay_written = relay_written_s2;
	assign panel_mode    = panel_mode_s2;
	assign master_event  = master_event_s2;
	assign fade_start    = fade_start_s2;
	assign fade_stop     = fade_stop_s2;
	assign master_light  = master_light_s2;
	assign group_codes   = group_codes_s2;

`include "grouped_relay_button_panel_core_assert.svh"

	`GRBP_ASSERT_NOW(a_stall_needs_item, button_stall, valid_s1,
		"input stalled with empty input register")
	`GRBP_ASSERT_NEXT(a_advance_gives_result, advance, result_valid_q,
		"processed transaction did not reach the result register")
	`GRBP_ASSERT_NOW(a_fade_exclusive, result_valid_q, !(fade_start_s2 && fade_stop_s2),
		"fade start and stop in the same transaction")
	`GRBP_ASSERT_NOW(a_fade_normal_only, result_valid_q && (fade_start_s2 || fade_stop_s2),
		relay_written_s2, "fade flag without a relay write")

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the grouped relay button panel core: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb_top;
	import grbp_pkg::*;

	localparam int NB          = 6;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_TICKS = 330;
	localparam int SHOW_MAX    = 10;

	typedef struct packed {
		logic [7:0]          port;
		logic                written;
		mode_t               mode;
		event_t              ev;
		logic                fs;
		logic                fe;
		logic                light;
		logic [GROUP_CODES_W-1:0] codes;
	} panel_result_t;

	// Tracks the panel state per tick and holds the results still to come.
	class panel_scoreboard;
		logic [7:0]    long_ticks;
		logic [7:0]    fill;
		logic [7:0]    last_pb;
		logic          pressed;
		logic [7:0]    hold_ticks;
		logic          timing;
		mode_t         mode;
		logic [NB-1:0] relays;
		logic [NB-1:0] last_relays;
		logic [2:0]    groups[NB];
		logic [NB-1:0] masks[NB];
		logic [3:0]    flash;
		panel_result_t due_q[$];
		int            errors;

		function new();
			long_ticks = LONG_PRESS_RESET;
			fill = FILL_MASK_RESET;
			last_pb = '0;
			pressed = 1'b0;
			hold_ticks = '0;
			timing = 1'b0;
			mode = MODE_STARTUP;
			relays = '0;
			last_relays = '0;
			flash = '0;
			errors = 0;
			for (int i = 0; i < NB; i++) begin
				groups[i] = i[2:0];
				masks[i] = NB'(1) << i;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void note_tick(logic [7:0] raw);
			logic [7:0]    pb;
			logic [7:0]    edges;
			logic [NB-1:0] g;
			panel_result_t r;
			pb = (raw & PB_KEEP) | ((raw & PB_RAW_HI) >> 1) | ((raw & PB_RAW_LO) << 1);
			edges = pb & ~last_pb;
			last_pb = pb;
			r = '0;
			r.ev = EV_NONE;
			r.light = 1'b1;

			if (timing && hold_ticks != TIMER_MAX)
				hold_ticks++;
			if (edges[MASTER_IDX]) begin
				// timer is not cleared on a new press
				timing = 1'b1;
				pressed = 1'b1;
				r.ev = EV_SHORT;
			end else if (timing && hold_ticks >= long_ticks) begin
				timing = 1'b0;
				hold_ticks = '0;
				pressed = 1'b0;
				r.ev = EV_LONG;
			end else if (pressed && !pb[MASTER_IDX]) begin
				timing = 1'b0;
				hold_ticks = '0;
				pressed = 1'b0;
				r.ev = EV_SHORT;
			end

			case (mode)
				MODE_NORMAL: begin
					if (r.ev != EV_NONE) begin
						relays = '0;
						r.written = 1'b1;
					end
					if (r.ev == EV_LONG)
						mode = MODE_PROG;
					// any edge rewrites the relays, even master or bit 7 alone
					if (edges != '0) begin
						g = '0;
						for (int i = 0; i < NB; i++)
							if (edges[i])
								g |= masks[groups[i]] ^ relays;
						relays = g;
						r.written = 1'b1;
					end
					r.fs = relays != '0 && last_relays == '0;
					r.fe = relays == '0 && last_relays != '0;
					last_relays = relays;
				end
				MODE_PROG: begin
					r.light = flash < FLASH_ON_LIMIT;
					if (flash > FLASH_WRAP)
						flash = '0;
					flash += FLASH_STEP;
					if (r.ev != EV_NONE) begin
						// masks come from the groups before this tick's steps
						mode = MODE_NORMAL;
						for (int m = 0; m < NB; m++) begin
							masks[m] = '0;
							for (int b = 0; b < NB; b++)
								if (groups[b] == m)
									masks[m][b] = 1'b1;
						end
						r.light = 1'b1;
					end
					for (int i = 0; i < NB; i++)
						if (edges[i])
							groups[i] = (groups[i] == NB - 1) ? 3'd0 : groups[i] + 3'd1;
				end
				default: mode = MODE_NORMAL;
			endcase

			for (int i = 0; i < NB; i++)
				r.codes[3*i +: 3] = groups[i];
			r.port = 8'(relays) | fill;
			r.mode = mode;
			due_q.push_back(r);
		endfunction

		function void fault(string msg);
			errors++;
			if (errors <= SHOW_MAX)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		function void check_result(panel_result_t got);
			panel_result_t exp;
			string diff;
			if (due_q.size() == 0) begin
				fault($sformatf("result with no tick pending: %h", got));
				return;
			end
			exp = due_q.pop_front();
			diff = "";
			if (got.port !== exp.port)
				diff = {diff, $sformatf(" relay_port exp %h got %h", exp.port, got.port)};
			if (got.written !== exp.written)
				diff = {diff, $sformatf(" relay_written exp %b got %b", exp.written, got.written)};
			if (got.mode !== exp.mode)
				diff = {diff, $sformatf(" panel_mode exp %0d got %0d", exp.mode, got.mode)};
			if (got.ev !== exp.ev)
				diff = {diff, $sformatf(" master_event exp %0d got %0d", exp.ev, got.ev)};
			if (got.fs !== exp.fs)
				diff = {diff, $sformatf(" fade_start exp %b got %b", exp.fs, got.fs)};
			if (got.fe !== exp.fe)
				diff = {diff, $sformatf(" fade_stop exp %b got %b", exp.fe, got.fe)};
			if (got.light !== exp.light)
				diff = {diff, $sformatf(" master_light exp %b got %b", exp.light, got.light)};
			if (got.codes !== exp.codes)
				diff = {diff, $sformatf(" group_codes exp %h got %h", exp.codes, got.codes)};
			if (diff != "")
				fault(diff);
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic                     cfg_index = CFG_LONG_PRESS;
	logic [7:0]               cfg_data = '0;
	logic                     button_valid = 1'b0;
	logic                     button_stall;
	logic [7:0]               button_byte = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic [7:0]               relay_port;
	logic                     relay_written;
	mode_t                    panel_mode;
	event_t                   master_event;
	logic                     fade_start;
	logic                     fade_stop;
	logic                     master_light;
	logic [GROUP_CODES_W-1:0] group_codes;

	panel_scoreboard sb = new();
	int              send_pct = 0;
	int              recv_pct = 0;
	int              phase_ticks = 0;
	int              quiet = 0;

	grouped_relay_button_panel_core #(.NUM_BUTTONS(NB)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.button_valid (button_valid),
		.button_stall (button_stall),
		.button_byte  (button_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.relay_port   (relay_port),
		.relay_written(relay_written),
		.panel_mode   (panel_mode),
		.master_event (master_event),
		.fade_start   (fade_start),
		.fade_stop    (fade_stop),
		.master_light (master_light),
		.group_codes  (group_codes)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit roll(int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	always @(posedge clk) begin
		result_stall <= roll(recv_pct);
	end

	// transaction monitors and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (button_valid && !button_stall)
				sb.note_tick(button_byte);
			if (result_valid && !result_stall)
				sb.check_result({relay_port, relay_written, panel_mode, master_event,
					fade_start, fade_stop, master_light, group_codes});
			if ((button_valid && !button_stall) || (result_valid && !result_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic drive_tick(input logic [7:0] b);
		while (roll(send_pct)) begin
			button_valid <= 1'b0;
			@(posedge clk);
		end
		button_valid <= 1'b1;
		button_byte <= b;
		@(posedge clk);
		while (button_stall)
			@(posedge clk);
		phase_ticks++;
	endtask

	// drop button_valid and wait for the clock first so the monitor has noted the last accepted tick
	task automatic settle();
		button_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] lp, input logic [7:0] fill);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_LONG_PRESS;
		cfg_data <= lp;
		@(posedge clk);
		sb.long_ticks = lp;
		cfg_index <= CFG_FILL_MASK;
		cfg_data <= fill;
		@(posedge clk);
		sb.fill = fill;
		cfg_we <= 1'b0;
	endtask

	task automatic tap_keys(input logic [7:0] keys);
		repeat ($urandom_range(3, 1)) drive_tick(keys);
		repeat ($urandom_range(2, 1)) drive_tick(8'h00);
	endtask

	// hold the master for n ticks, with the odd group key going by meanwhile
	task automatic hold_master(input int n);
		repeat (n) drive_tick(8'h40 | (roll(10) ? 8'($urandom_range(63, 0)) : 8'h00));
		repeat ($urandom_range(2, 1)) drive_tick(8'h00);
	endtask

	function automatic logic [7:0] random_keys();
		logic [7:0] k;
		k = 8'($urandom_range(63, 1));
		if (roll(10))
			k |= 8'h80;
		return k;
	endfunction

	task automatic random_phase();
		int lp;
		int r;
		lp = sb.long_ticks;
		phase_ticks = 0;
		while (phase_ticks < PHASE_TICKS) begin
			r = $urandom_range(99, 0);
			if (r < 10) begin
				repeat ($urandom_range(4, 1)) drive_tick(8'($urandom_range(255, 0)));
			end else if (r < 25) begin
				hold_master($urandom_range(lp < 8 ? lp : 8, 1));
			end else if (r < 85 || (lp > 64 && r < 95)) begin
				tap_keys(random_keys());
			end else begin
				// programming session: long press, group steps, master to leave
				hold_master(lp + $urandom_range(3, 1));
				repeat ($urandom_range(6, 1)) tap_keys(random_keys());
				tap_keys(8'h40);
			end
		end
	endtask

	initial begin
		logic [7:0] directed[] = '{8'h00, 8'h01, 8'h00, 8'h01, 8'h3F, 8'h00, 8'h80, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h10, 8'h20, 8'h00, 8'h01, 8'h40, 8'h00,
			8'h30, 8'h00, 8'h40, 8'h00};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(8'd2, 8'h00);
		foreach (directed[i])
			drive_tick(directed[i]);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_config(8'd1, 8'h00);
				1: set_config(8'd255, 8'hFF);
				2: set_config(LONG_PRESS_RESET, FILL_MASK_RESET);
				default: set_config(8'($urandom_range(255, 1)), 8'($urandom_range(255, 0)));
			endcase
			send_pct = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 8 : 0;
			recv_pct = (ph % 4 == 2) ? 47 : (ph % 4 == 3) ? 8 : 0;
			random_phase();
		end

		settle();
		recv_pct = 0;
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.fault($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/grbp_pkg.sv
sv/grbp_master.sv
sv/grbp_groups.sv
sv/grouped_relay_button_panel_core.sv
sim/tb_top.sv
